### rtl/stt_pkg.sv
// Shared types and codes for the search transposition table.
// No dependencies; imported by search_transposition_table.
`timescale 1ns / 1ps

package stt_pkg;

    // slot kind codes as stored in the table
    typedef enum logic [1:0] {
        KIND_UPPER = 2'd0,
        KIND_LOWER = 2'd1,
        KIND_EXACT = 2'd2,
        KIND_EMPTY = 2'd3
    } t_kind;

    // request codes
    localparam logic REQ_PROBE  = 1'b0;
    localparam logic REQ_RECORD = 1'b1;

    // one table slot as held in the memory word
    typedef struct packed {
        logic [63:0] key;
        logic [31:0] value;
        logic [3:0]  depth;
        t_kind       kind;
    } t_entry;

endpackage

### rtl/search_transposition_table.sv
// Direct-mapped transposition table with depth-preferred replacement.
// Request stage registers the beat and slot read, output register the result; one
//   beat per cycle unless i_out_ready stalls; bounded by the slot read-modify-write.
// Same-slot beats back to back are served by a one-entry write forward register.
// Reset: synchronous, active low; afterwards a clearing pass marks all 2**INDEX_BITS
//   slots empty, one per cycle, and no input beat is taken until it ends.
// Depends on stt_pkg.
`timescale 1ns / 1ps

module search_transposition_table #(
    parameter int INDEX_BITS = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_req_type,
    input  logic signed [63:0] i_position_key,
    input  logic [3:0]         i_search_depth,
    input  logic signed [31:0] i_entry_value,
    input  logic [1:0]         i_bound_kind,
    input  logic signed [31:0] i_alpha_bound,
    input  logic signed [31:0] i_beta_bound,

    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_hit,
    output logic signed [31:0] o_result_value
);

    import stt_pkg::*;

    localparam int SLOTS = 1 << INDEX_BITS;

    // slot memory
    t_entry mem [SLOTS];

    // clearing pass
    logic                  r_clr_busy;
    logic [INDEX_BITS-1:0] r_clr_idx;

    // request stage, aligned with the registered read data
    logic                  r_s1_valid;
    logic                  r_s1_req;
    logic [63:0]           r_s1_key;
    logic [3:0]            r_s1_depth;
    logic [31:0]           r_s1_value;
    logic [1:0]            r_s1_kind;
    logic [31:0]           r_s1_alpha;
    logic [31:0]           r_s1_beta;
    t_entry                r_rdata;

    // last write, for a read taken on the same edge
    logic                  r_fwd_valid;
    logic [INDEX_BITS-1:0] r_fwd_idx;
    t_entry                r_fwd_data;

    // output register
    logic                  r_out_valid;
    logic                  r_out_hit;
    logic [31:0]           r_out_value;

    logic                  in_fire;
    logic                  s1_fire;
    logic [INDEX_BITS-1:0] in_idx;
    logic [INDEX_BITS-1:0] s1_idx;
    t_entry                cur;
    logic                  occupied;
    logic                  upd;
    t_entry                upd_data;
    logic                  n_hit;
    logic [31:0]           n_value;
    logic                  wr_en;
    logic [INDEX_BITS-1:0] wr_addr;
    t_entry                wr_data;

    assign in_idx = i_position_key[INDEX_BITS-1:0];
    assign s1_idx = r_s1_key[INDEX_BITS-1:0];

    assign s1_fire    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_clr_busy && (!r_s1_valid || s1_fire);
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        cur = (r_fwd_valid && r_fwd_idx == s1_idx) ? r_fwd_data : r_rdata;
        occupied = cur.kind != KIND_EMPTY;

        // record: equal depth replaces, greater stored depth keeps the slot
        upd = (r_s1_req == REQ_RECORD) && (r_s1_kind != KIND_EMPTY)
              && !(occupied && cur.depth > r_s1_depth);
        upd_data.key   = r_s1_key;
        upd_data.value = r_s1_value;
        upd_data.depth = r_s1_depth;
        upd_data.kind  = t_kind'(r_s1_kind);

        n_hit   = 1'b0;
        n_value = '0;
        if (r_s1_req == REQ_PROBE && occupied && cur.key == r_s1_key
            && cur.depth >= r_s1_depth) begin
            case (cur.kind)
                KIND_EXACT: begin
                    n_hit   = 1'b1;
                    n_value = cur.value;
                end
                KIND_UPPER: begin
                    if ($signed(cur.value) <= $signed(r_s1_alpha)) begin
                        n_hit   = 1'b1;
                        n_value = r_s1_alpha;
                    end
                end
                KIND_LOWER: begin
                    if ($signed(cur.value) >= $signed(r_s1_beta)) begin
                        n_hit   = 1'b1;
                        n_value = r_s1_beta;
                    end
                end
                default: begin
                    n_hit   = 1'b0;
                    n_value = '0;
                end
            endcase
        end

        if (r_clr_busy) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_idx;
            wr_data = '{key: '0, value: '0, depth: '0, kind: KIND_EMPTY};
        end else begin
            wr_en   = s1_fire && upd;
            wr_addr = s1_idx;
            wr_data = upd_data;
        end
    end

    // memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (in_fire) begin
            r_rdata <= mem[in_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_idx   <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + INDEX_BITS'(1);
                if (&r_clr_idx) begin
                    r_clr_busy <= 1'b0;
                end
            end

            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_fire && upd) begin
                r_fwd_valid <= 1'b1;
            end

            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_req   <= i_req_type;
            r_s1_key   <= i_position_key;
            r_s1_depth <= i_search_depth;
            r_s1_value <= i_entry_value;
            r_s1_kind  <= i_bound_kind;
            r_s1_alpha <= i_alpha_bound;
            r_s1_beta  <= i_beta_bound;
        end
        if (s1_fire && upd) begin
            r_fwd_idx  <= s1_idx;
            r_fwd_data <= upd_data;
        end
        if (s1_fire) begin
            r_out_hit   <= n_hit;
            r_out_value <= n_value;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_out_hit;
    assign o_result_value = r_out_value;

    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !o_in_ready)
        else $error("input beat offered ready during clearing pass");

    a_clear_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (!r_s1_valid && !r_out_valid))
        else $error("request in flight during clearing pass");

    a_accept_loads_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_s1_valid)
        else $error("accepted beat lost before request stage");

    a_fwd_tracks_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && upd) |=> (r_fwd_valid && r_fwd_idx == $past(s1_idx)))
        else $error("forward register missed a slot write");

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_hit) |-> (r_out_value == '0))
        else $error("miss or record result carries a non-zero score");

endmodule
